// ===== hw/rtl/half_step_stepper_toggle_ctrl_top_assert.svh =====
// assertion macros shared by the checker file
`ifndef HALF_STEP_STEPPER_TOGGLE_CTRL_TOP_ASSERT_SVH
`define HALF_STEP_STEPPER_TOGGLE_CTRL_TOP_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define HSST_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: same-cycle rule");

// next-cycle implication, quiet while reset is high
`define HSST_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle rule");

`endif

// ===== hw/rtl/hsst_pkg.sv =====
package hsst_pkg;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS    = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_PERIOD_TICKS = 1'b1;

   localparam int unsigned DEBOUNCE_WIDTH = 16;
   localparam int unsigned PERIOD_WIDTH   = 8;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 16'd30;
   localparam logic [PERIOD_WIDTH-1:0]   PERIOD_RESET   = 8'd2;

   typedef enum logic [1:0] {
      MODE_HALT = 2'd0,
      MODE_FWD  = 2'd1,
      MODE_REV  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [3:0] coil_drive;
      mode_type   run_mode;
      logic [2:0] phase_index;
      logic       step_taken;
   } tick_result_type;

   // half-step coil pattern, bit0 is the first coil
   function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
      logic [3:0] coils;
      case (phase)
         3'd0:    coils = 4'h1;
         3'd1:    coils = 4'h3;
         3'd2:    coils = 4'h2;
         3'd3:    coils = 4'h6;
         3'd4:    coils = 4'h4;
         3'd5:    coils = 4'hC;
         3'd6:    coils = 4'h8;
         3'd7:    coils = 4'h9;
         default: coils = 4'h0;
      endcase
      return coils;
   endfunction

endpackage

// ===== hw/rtl/hsst_debounce.sv =====
module hsst_debounce #(
   parameter int unsigned STABLE_COUNT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 raw,
   input  logic [hsst_pkg::DEBOUNCE_WIDTH-1:0]  threshold,
   output logic                                 press
);

   localparam int unsigned CmpW = (STABLE_COUNT_WIDTH > hsst_pkg::DEBOUNCE_WIDTH) ?
                                  STABLE_COUNT_WIDTH : hsst_pkg::DEBOUNCE_WIDTH;

   logic                          last_ff, last_in;
   logic                          level_ff, level_in;
   logic [STABLE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                          accept;

   always_comb begin
      last_in = raw;
      if (raw != last_ff) begin
         count_in = '0;
      end else if (count_ff != {STABLE_COUNT_WIDTH{1'b1}}) begin
         count_in = count_ff + STABLE_COUNT_WIDTH'(1);
      end else begin
         count_in = count_ff;
      end
      // stable long enough and the level really moves
      accept   = (CmpW'(count_in) > CmpW'(threshold)) && (raw != level_ff);
      level_in = accept ? raw : level_ff;
      press    = accept && raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= 1'b0;
         level_ff <= 1'b0;
         count_ff <= '0;
      end else if (advance) begin
         last_ff  <= last_in;
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/hsst_motion.sv =====
module hsst_motion (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                fwd_press,
   input  logic                                rev_press,
   input  logic [hsst_pkg::PERIOD_WIDTH-1:0]   step_period,
   output hsst_pkg::tick_result_type           result
);

   hsst_pkg::mode_type                mode_ff, mode_in;
   logic [2:0]                        phase_ff, phase_in;
   logic [hsst_pkg::PERIOD_WIDTH-1:0] timer_ff, timer_in;
   logic                              running;
   logic                              taken;

   always_comb begin
      mode_in = mode_ff;
      if (fwd_press) begin
         mode_in = (mode_in == hsst_pkg::MODE_FWD) ? hsst_pkg::MODE_HALT : hsst_pkg::MODE_FWD;
      end
      // reverse handled second so it wins a tie
      if (rev_press) begin
         mode_in = (mode_in == hsst_pkg::MODE_REV) ? hsst_pkg::MODE_HALT : hsst_pkg::MODE_REV;
      end
      running  = (mode_in == hsst_pkg::MODE_FWD) || (mode_in == hsst_pkg::MODE_REV);
      taken    = running && (timer_ff == '0);
      phase_in = phase_ff;
      timer_in = '0;
      if (taken) begin
         phase_in = (mode_in == hsst_pkg::MODE_FWD) ? phase_ff + 3'd1 : phase_ff - 3'd1;
         // a zero period behaves as one
         timer_in = (step_period == '0) ? '0 : step_period - hsst_pkg::PERIOD_WIDTH'(1);
      end else if (running) begin
         timer_in = timer_ff - hsst_pkg::PERIOD_WIDTH'(1);
      end
      result.coil_drive  = running ? hsst_pkg::coil_pattern(phase_in) : 4'h0;
      result.run_mode    = mode_in;
      result.phase_index = phase_in;
      result.step_taken  = taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= hsst_pkg::MODE_HALT;
         phase_ff <= 3'd0;
         timer_ff <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         timer_ff <= timer_in;
      end
   end

endmodule

// ===== hw/rtl/half_step_stepper_toggle_ctrl_top.sv =====
// half-step stepper sequencer with two debounced toggle buttons. each req beat is one
// millisecond tick carrying the raw forward and reverse button levels; each tick gives
// exactly one rsp beat with the coil drive, run mode, phase index and a step flag. the
// block takes one beat every clock cycle while the rsp side keeps up; each request beat goes
// through the input register, then the single pass of debounce, mode and step logic into the
// result register. the result register frees as it is read, so a stalled rsp side only stops
// req once both registers hold a beat. debounce threshold (reset 30) and step period
// (reset 2) must be set via the csr port with no tick in flight; the block does not enforce it.
module half_step_stepper_toggle_ctrl_top #(
   parameter int unsigned STABLE_COUNT_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request side
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // fwd_button_raw, rev_button_raw, zero pad
   // result side
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [15:0]                           rsp_tdata,  // coil_drive[3:0], run_mode[5:4],
                                                             // phase_index[8:6], step_taken[9], zero pad
   // configuration writes
   input  logic                                  csr_we,
   input  logic [hsst_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [hsst_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   // configuration registers
   logic [hsst_pkg::DEBOUNCE_WIDTH-1:0] debounce_ticks_ff;
   logic [hsst_pkg::PERIOD_WIDTH-1:0]   step_period_ticks_ff;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_fwd_ff, in_rev_ff;

   // result register
   logic                      out_valid_ff, out_valid_in;
   hsst_pkg::tick_result_type out_ff;
   hsst_pkg::tick_result_type result;

   logic out_free;   // result register may take a beat this cycle
   logic advance;    // the held tick is worked through this cycle
   logic fwd_press, rev_press;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff    <= hsst_pkg::DEBOUNCE_RESET;
         step_period_ticks_ff <= hsst_pkg::PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hsst_pkg::CSR_DEBOUNCE_TICKS: begin
               debounce_ticks_ff <= csr_wdata[hsst_pkg::DEBOUNCE_WIDTH-1:0];
            end
            hsst_pkg::CSR_STEP_PERIOD_TICKS: begin
               step_period_ticks_ff <= csr_wdata[hsst_pkg::PERIOD_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline handshake: each stage moves when the one after it can take a beat
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_fwd_ff <= req_tdata[0];
         in_rev_ff <= req_tdata[1];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   // per-button debounce, state only moves when a tick is worked through
   hsst_debounce #(
      .STABLE_COUNT_WIDTH (STABLE_COUNT_WIDTH)
   ) u_fwd_debounce (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .raw       (in_fwd_ff),
      .threshold (debounce_ticks_ff),
      .press     (fwd_press)
   );

   hsst_debounce #(
      .STABLE_COUNT_WIDTH (STABLE_COUNT_WIDTH)
   ) u_rev_debounce (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .raw       (in_rev_ff),
      .threshold (debounce_ticks_ff),
      .press     (rev_press)
   );

   // mode toggling, step timer and coil pattern
   hsst_motion u_motion (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .fwd_press   (fwd_press),
      .rev_press   (rev_press),
      .step_period (step_period_ticks_ff),
      .result      (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.step_taken, out_ff.phase_index,
                        out_ff.run_mode, out_ff.coil_drive};

endmodule

// ===== hw/rtl/hsst_checker.sv =====
`include "half_step_stepper_toggle_ctrl_top_assert.svh"

module hsst_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [15:0]  rsp_tdata
);

   // a stalled result beat holds
   `HSST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata))

   // stopped means coils off
   `HSST_ASSERT_NOW(a_stop_coils_off, clock, reset, rsp_tvalid && (rsp_tdata[5:4] == 2'd0),
                    rsp_tdata[3:0] == 4'd0)

   // running always drives at least one coil
   `HSST_ASSERT_NOW(a_run_coils_on, clock, reset, rsp_tvalid && (rsp_tdata[5:4] != 2'd0),
                    rsp_tdata[3:0] != 4'd0)

   // a step is only reported while running
   `HSST_ASSERT_NOW(a_step_needs_run, clock, reset, rsp_tvalid && rsp_tdata[9],
                    rsp_tdata[5:4] != 2'd0)

   // req only stalls behind a waiting, unread result beat
   `HSST_ASSERT_NOW(a_req_stall_full, clock, reset, !req_tready,
                    rsp_tvalid && !rsp_tready)

endmodule

bind half_step_stepper_toggle_ctrl_top hsst_checker u_hsst_checker (.*);
